[sv/stpm_pkg.sv]
// Package for the string table prefix matcher.
// Holds default sizes, field widths, op codes and the lane control struct.
// Depends on nothing; every other file of the block imports it.
package stpm_pkg;

  // Default table geometry.
  localparam int unsigned DefaultEntries = 16;
  localparam int unsigned DefaultMaxLen  = 16;

  // Fixed field widths of the beat payloads.
  localparam int unsigned OpW     = 2;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned PosW    = 4;
  localparam int unsigned CharW   = 8;
  localparam int unsigned LengthW = 5;

  // Op codes of an input beat. The fourth code is unused and ignored.
  localparam logic [OpW-1:0] OP_CHAR   = 2'd0;
  localparam logic [OpW-1:0] OP_LEN    = 2'd1;
  localparam logic [OpW-1:0] OP_SEARCH = 2'd2;

  // Commands broadcast from the top level to every lane.
  typedef struct packed {
    logic chr_we;  // write one table character
    logic len_we;  // write one entry length
    logic step;    // compare the current search character
    logic clear;   // search string ends, rearm the match flag
  } lane_ctrl_t;

endpackage

[sv/stpm_lane.sv]
// One table entry of the string table prefix matcher: character store,
// length register, match flag and the per-character compare.
// Depends on stpm_pkg.
module stpm_lane import stpm_pkg::*; #(
  parameter int unsigned MAX_LEN = DefaultMaxLen,
  parameter int unsigned LANE    = 0,
  parameter int unsigned AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  parameter int unsigned CW      = $clog2(MAX_LEN + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lane_ctrl_t        ctrl_i,
  input  logic [IndexW-1:0] entry_index_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [CharW-1:0]  char_value_i,
  input  logic [CW-1:0]     wr_length_i,
  input  logic [AW-1:0]     rd_addr_i,
  input  logic [CW-1:0]     count_i,
  output logic              hit_o,
  output logic [CW-1:0]     length_o
);

  logic [CharW-1:0] mem [MAX_LEN];
  logic [CharW-1:0] rd_q;
  logic [CW-1:0]    len_q;
  logic             flag_q, flag_d;
  logic             sel;
  logic             mem_we;
  logic             mismatch;
  logic [CW-1:0]    count_next;

  assign sel    = (int'(entry_index_i) == int'(LANE));
  assign mem_we = ctrl_i.chr_we && sel;

  // The read port is registered; a write to the address being fetched is
  // forwarded so that the next search character sees it.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr_i] <= char_value_i;
    end
    if (mem_we && (wr_addr_i == rd_addr_i)) begin
      rd_q <= char_value_i;
    end else begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.len_we && sel) begin
      len_q <= wr_length_i;
    end
  end

  assign mismatch   = ctrl_i.step && (count_i < len_q) && (rd_q != char_value_i);
  assign flag_d     = flag_q && !mismatch;
  assign count_next = count_i + CW'(ctrl_i.step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b1;
    end else if (ctrl_i.clear) begin
      flag_q <= 1'b1;
    end else begin
      flag_q <= flag_d;
    end
  end

  assign hit_o    = flag_d && (len_q <= count_next);
  assign length_o = len_q;

endmodule

[sv/stpm_select.sv]
// Priority selection of the lowest-indexed matching entry in use.
// Depends on stpm_pkg.
module stpm_select import stpm_pkg::*; #(
  parameter int unsigned ENTRIES = DefaultEntries,
  parameter int unsigned CW      = $clog2(DefaultMaxLen + 1),
  parameter int unsigned EW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int unsigned UW      = $clog2(ENTRIES + 1)
) (
  input  logic [ENTRIES-1:0]         hit_i,
  input  logic [ENTRIES-1:0][CW-1:0] length_i,
  input  logic [UW-1:0]              used_i,
  output logic                       found_o,
  output logic [EW-1:0]              index_o,
  output logic [CW-1:0]              length_o
);

  // Scan from the top so that the lowest hit is the one that remains.
  always_comb begin
    found_o  = 1'b0;
    index_o  = '0;
    length_o = '0;
    for (int i = int'(ENTRIES) - 1; i >= 0; i--) begin
      if (hit_i[i] && (i < int'(used_i))) begin
        found_o  = 1'b1;
        index_o  = EW'(i);
        length_o = length_i[i];
      end
    end
  end

endmodule

[sv/string_table_prefix_match.sv]
// String table prefix matcher. The block keeps a table of up to ENTRIES
// strings of at most MAX_LEN characters, loaded one character or one
// length per input beat. A search string then streams in one character
// per beat, its final character flagged by last; for that character the
// block returns one result beat with the lowest-indexed entry in use that
// is a prefix of (or equal to) the search string, and that entry's length.
// An entry of length zero matches every search, search characters beyond
// MAX_LEN are ignored, and lengths above MAX_LEN are stored as MAX_LEN.
// Every op, search or table write, passes through the input register: a new
// beat can be accepted each clock unless the result register stalls it, and a
// search result goes from the input register into the result register. The
// rate is set by the per-entry character compare, done for all entries at once
// from a registered read of each entry's character store. Only the result
// register can stall the input.
// The register entry_count must be written while no beat is in flight.
// Depends on stpm_pkg, stpm_lane and stpm_select.
module string_table_prefix_match import stpm_pkg::*; #(
  parameter int unsigned ENTRIES = DefaultEntries,
  parameter int unsigned MAX_LEN = DefaultMaxLen
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port for entry_count.
  input  logic               cfg_we_i,
  input  logic [LengthW-1:0] cfg_wdata_i,
  // Input beat channel.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OpW-1:0]     op_i,
  input  logic [IndexW-1:0]  entry_index_i,
  input  logic [PosW-1:0]    position_i,
  input  logic [CharW-1:0]   char_value_i,
  input  logic [LengthW-1:0] entry_length_i,
  input  logic               last_i,
  // Result beat channel.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [IndexW-1:0]  match_index_o,
  output logic [LengthW-1:0] matched_length_o
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned UW = $clog2(ENTRIES + 1);

  // Configuration register.
  logic [LengthW-1:0] entry_count_q;
  logic [UW-1:0]      used;

  // Input register.
  logic               in_vld_q;
  logic [OpW-1:0]     op_q;
  logic [IndexW-1:0]  idx_q;
  logic [PosW-1:0]    pos_q;
  logic [CharW-1:0]   ch_q;
  logic [LengthW-1:0] elen_q;
  logic               last_q;

  // Search state and control.
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      rd_addr;
  logic [CW-1:0]      elen_sat;
  logic               is_search;
  logic               emits;
  logic               out_free;
  logic               commit;
  lane_ctrl_t         ctrl;

  // Lane outputs and selection.
  logic [ENTRIES-1:0]         hit;
  logic [ENTRIES-1:0][CW-1:0] lane_len;
  logic                       sel_found;
  logic [EW-1:0]              sel_index;
  logic [CW-1:0]              sel_length;

  // Result register.
  logic               out_vld_q;
  logic               found_q;
  logic [IndexW-1:0]  match_index_q;
  logic [LengthW-1:0] matched_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  // A count above the table size acts as the table size.
  assign used = (int'(entry_count_q) > int'(ENTRIES)) ? UW'(ENTRIES) : UW'(entry_count_q);

  // A beat in the input register commits unless it must hand a result to
  // a result register that is still full.
  assign is_search  = (op_q == OP_SEARCH);
  assign emits      = is_search && last_q;
  assign out_free   = !out_vld_q || out_ready_i;
  assign commit     = in_vld_q && (!emits || out_free);
  assign in_ready_o = !in_vld_q || commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= op_i;
      idx_q  <= entry_index_i;
      pos_q  <= position_i;
      ch_q   <= char_value_i;
      elen_q <= entry_length_i;
      last_q <= last_i;
    end
  end

  // Out-of-range writes simply do not reach any lane.
  always_comb begin
    ctrl.chr_we = commit && (op_q == OP_CHAR) && (int'(idx_q) < int'(ENTRIES))
                  && (int'(pos_q) < int'(MAX_LEN));
    ctrl.len_we = commit && (op_q == OP_LEN) && (int'(idx_q) < int'(ENTRIES));
    ctrl.step   = commit && is_search && (int'(count_q) < int'(MAX_LEN));
    ctrl.clear  = commit && emits;
  end

  assign elen_sat = (int'(elen_q) > int'(MAX_LEN)) ? CW'(MAX_LEN) : CW'(elen_q);

  // The search counter saturates at MAX_LEN and rearms after the final
  // character.
  always_comb begin
    count_d = count_q;
    if (ctrl.clear) begin
      count_d = '0;
    end else if (ctrl.step) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // The stores are fetched at the position the next search character will
  // use. At saturation no compare happens, so the address is a don't care.
  assign rd_addr = (int'(count_d) < int'(MAX_LEN)) ? count_d[AW-1:0] : '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_lane
    stpm_lane #(
      .MAX_LEN (MAX_LEN),
      .LANE    (g),
      .AW      (AW),
      .CW      (CW)
    ) u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .entry_index_i (idx_q),
      .wr_addr_i     (AW'(pos_q)),
      .char_value_i  (ch_q),
      .wr_length_i   (elen_sat),
      .rd_addr_i     (rd_addr),
      .count_i       (count_q),
      .hit_o         (hit[g]),
      .length_o      (lane_len[g])
    );
  end

  stpm_select #(
    .ENTRIES (ENTRIES),
    .CW      (CW),
    .EW      (EW),
    .UW      (UW)
  ) u_select (
    .hit_i    (hit),
    .length_i (lane_len),
    .used_i   (used),
    .found_o  (sel_found),
    .index_o  (sel_index),
    .length_o (sel_length)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl.clear) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.clear) begin
      found_q          <= sel_found;
      match_index_q    <= IndexW'(sel_index);
      matched_length_q <= LengthW'(sel_length);
    end
  end

  assign out_valid_o      = out_vld_q;
  assign found_o          = found_q;
  assign match_index_o    = match_index_q;
  assign matched_length_o = matched_length_q;

endmodule

[dv/string_table_prefix_match_checker.sv]
`timescale 1ns / 1ps
// Checker for the string table prefix matcher: watches both beat channels and the
// entry_count write port, predicts each search result and compares it in order.
// Depends on stpm_pkg for field widths and op codes.
module string_table_prefix_match_checker import stpm_pkg::*; #(
  parameter int unsigned ENTRIES = DefaultEntries,
  parameter int unsigned MAX_LEN = DefaultMaxLen
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LengthW-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [OpW-1:0]     op_i,
  input  logic [IndexW-1:0]  entry_index_i,
  input  logic [PosW-1:0]    position_i,
  input  logic [CharW-1:0]   char_value_i,
  input  logic [LengthW-1:0] entry_length_i,
  input  logic               last_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               found_i,
  input  logic [IndexW-1:0]  match_index_i,
  input  logic [LengthW-1:0] matched_length_i,
  output int                 error_count_o,
  output int                 pending_o,
  output int                 results_o,
  output int                 hits_o
);

  typedef struct packed {
    logic               found;
    logic [IndexW-1:0]  index;
    logic [LengthW-1:0] length;
  } match_t;

  logic [CharW-1:0]   char_mem [ENTRIES][MAX_LEN];
  logic [LengthW-1:0] len_mem  [ENTRIES];
  logic [ENTRIES-1:0] alive;
  int unsigned        chars_seen;
  int unsigned        used_entries;
  int                 errors;
  int                 results;
  int                 hits;
  match_t             match_q [$];
  match_t             want;
  match_t             got;
  match_t             best;

  // All sampling happens right after the edge, so every signal read here still
  // holds the value it had when the edge came.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int e = 0; e < ENTRIES; e++) begin
        len_mem[e] = '0;
        for (int p = 0; p < MAX_LEN; p++) char_mem[e][p] = '0;
      end
      alive        = '1;
      chars_seen   = 0;
      used_entries = 0;
      errors       = 0;
      results      = 0;
      hits         = 0;
      match_q.delete();
    end else begin
      if (cfg_we_i) used_entries = (cfg_wdata_i > ENTRIES) ? ENTRIES : cfg_wdata_i;

      // A result can never come out on the edge that takes its last character,
      // so results are retired before the new beat is predicted.
      if (out_valid_i && out_ready_i) begin
        got = {found_i, match_index_i, matched_length_i};
        if (match_q.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: found=%0d index=%0d length=%0d",
                   $time, got.found, got.index, got.length);
        end else begin
          want = match_q.pop_front();
          results++;
          if (want.found) hits++;
          if (got !== want) begin
            errors++;
            $display({"%0t: result mismatch: expected found=%0d index=%0d length=%0d,",
                      " got %0d %0d %0d"},
                     $time, want.found, want.index, want.length,
                     got.found, got.index, got.length);
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        case (op_i)
          OP_CHAR: begin
            if (entry_index_i < ENTRIES && position_i < MAX_LEN)
              char_mem[entry_index_i][position_i] = char_value_i;
          end
          OP_LEN: begin
            if (entry_index_i < ENTRIES)
              len_mem[entry_index_i] = (entry_length_i > MAX_LEN) ? LengthW'(MAX_LEN)
                                                                  : entry_length_i;
          end
          OP_SEARCH: begin
            // Past MAX_LEN characters the search string is no longer compared.
            if (chars_seen < MAX_LEN) begin
              for (int e = 0; e < ENTRIES; e++)
                if (chars_seen < len_mem[e] && char_mem[e][chars_seen] != char_value_i)
                  alive[e] = 1'b0;
              chars_seen++;
            end
            if (last_i) begin
              best = '0;
              for (int e = 0; e < used_entries; e++)
                if (!best.found && alive[e] && len_mem[e] <= chars_seen)
                  best = {1'b1, IndexW'(e), len_mem[e]};
              match_q.push_back(best);
              alive      = '1;
              chars_seen = 0;
            end
          end
          default: ;
        endcase
      end
    end
    error_count_o <= errors;
    pending_o     <= match_q.size();
    results_o     <= results;
    hits_o        <= hits;
  end

endmodule

[dv/string_table_prefix_match_tb.sv]
`timescale 1ns / 1ps
// Top of the string table prefix matcher testbench: clock, reset, beat stimulus,
// result back-pressure and the verdict. Depends on stpm_pkg, the block and the checker.
module string_table_prefix_match_tb;
  import stpm_pkg::*;

  localparam int unsigned Entries = DefaultEntries;
  localparam int unsigned MaxLen  = DefaultMaxLen;

  // The fourth op code has no name in the package; the block ignores it.
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  localparam int HalfPeriod  = 4;
  localparam int ResetCycles = 8;
  localparam int RandomItems = 400;
  localparam int MinResults  = 48;
  // Drain wait after the last expected result, with a little margin on top.
  localparam int DrainCycles = 4;
  localparam int CycleLimit  = 1000000;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               cfg_we_i         = 1'b0;
  logic [LengthW-1:0] cfg_wdata_i      = '0;
  logic               in_valid_i       = 1'b0;
  logic               in_ready_o;
  logic [OpW-1:0]     op_i             = OP_CHAR;
  logic [IndexW-1:0]  entry_index_i    = '0;
  logic [PosW-1:0]    position_i       = '0;
  logic [CharW-1:0]   char_value_i     = '0;
  logic [LengthW-1:0] entry_length_i   = '0;
  logic               last_i           = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i      = 1'b0;
  logic               found_o;
  logic [IndexW-1:0]  match_index_o;
  logic [LengthW-1:0] matched_length_o;

  int error_count;
  int pending_count;
  int result_count;
  int hit_count;

  // Stimulus-side picture of the table. It is only used to build legal and
  // interesting beats: a length is written only once the characters it covers
  // exist, and searches are copied from stored strings so that matches happen.
  bit [CharW-1:0] shadow_chr [Entries][MaxLen];
  bit             chr_written [Entries][MaxLen];
  int             shadow_len [Entries];

  int          beat_count  = 0;
  int          cfg_count   = 0;
  bit          fast_phase  = 1'b0;
  int unsigned cycle_count = 0;

  always #HalfPeriod clk_i = ~clk_i;

  string_table_prefix_match #(
    .ENTRIES(Entries),
    .MAX_LEN(MaxLen)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .entry_index_i   (entry_index_i),
    .position_i      (position_i),
    .char_value_i    (char_value_i),
    .entry_length_i  (entry_length_i),
    .last_i          (last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .found_o         (found_o),
    .match_index_o   (match_index_o),
    .matched_length_o(matched_length_o)
  );

  string_table_prefix_match_checker #(
    .ENTRIES(Entries),
    .MAX_LEN(MaxLen)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .op_i            (op_i),
    .entry_index_i   (entry_index_i),
    .position_i      (position_i),
    .char_value_i    (char_value_i),
    .entry_length_i  (entry_length_i),
    .last_i          (last_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .found_i         (found_o),
    .match_index_i   (match_index_o),
    .matched_length_i(matched_length_o),
    .error_count_o   (error_count),
    .pending_o       (pending_count),
    .results_o       (result_count),
    .hits_o          (hit_count)
  );

  // Result back-pressure. Ready runs and stalls are picked at random; most stalls
  // are short, a few are long, and now and then a long ready stretch lets the
  // block run at full rate.
  int sink_left = 0;
  bit sink_on   = 1'b0;
  int sink_pick;

  always @(posedge clk_i) begin
    if (sink_left == 0) begin
      sink_pick = $urandom_range(0, 99);
      if (sink_pick < 40) begin
        sink_on   = 1'b1;
        sink_left = $urandom_range(1, 20);
      end else if (sink_pick < 55) begin
        sink_on   = 1'b1;
        sink_left = $urandom_range(50, 150);
      end else if (sink_pick < 90) begin
        sink_on   = 1'b0;
        sink_left = $urandom_range(1, 3);
      end else begin
        sink_on   = 1'b0;
        sink_left = $urandom_range(10, 40);
      end
    end else begin
      sink_left--;
    end
    out_ready_i <= sink_on;
  end

  // Watchdog: a hung handshake must not keep the run going forever.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("string_table_prefix_match_tb NOT OK");
      $finish;
    end
  end

  // Mostly a four-letter alphabet so that stored strings share prefixes, with
  // full-range bytes mixed in so every bit of the character field toggles.
  function automatic logic [CharW-1:0] pick_char();
    if ($urandom_range(0, 9) < 8) return CharW'("a" + $urandom_range(0, 3));
    return CharW'($urandom_range(0, 255));
  endfunction

  // Offers one beat and returns at the edge that accepts it. Valid is either
  // kept high into the next beat or dropped for a gap, never both in one step.
  task automatic send_beat(input logic [OpW-1:0] op, input logic [IndexW-1:0] idx,
                           input logic [PosW-1:0] pos, input logic [CharW-1:0] ch,
                           input logic [LengthW-1:0] len, input logic last);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (fast_phase || pick < 50) gap = 0;
    else if (pick < 85) gap = $urandom_range(1, 3);
    else if (pick < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    entry_index_i  <= idx;
    position_i     <= pos;
    char_value_i   <= ch;
    entry_length_i <= len;
    last_i         <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (op != OpUnused) beat_count++;
  endtask

  // Table writes carry random values in the fields they do not use.
  task automatic write_char(input int e, input int p, input logic [CharW-1:0] ch);
    shadow_chr[e][p]  = ch;
    chr_written[e][p] = 1'b1;
    send_beat(OP_CHAR, IndexW'(e), PosW'(p), ch, LengthW'($urandom_range(0, 31)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic write_len(input int e, input int code);
    shadow_len[e] = (code > MaxLen) ? MaxLen : code;
    send_beat(OP_LEN, IndexW'(e), PosW'($urandom_range(0, 15)), CharW'($urandom_range(0, 255)),
              LengthW'(code), 1'($urandom_range(0, 1)));
  endtask

  // Writes the characters an entry of this length covers, then the length.
  task automatic load_entry(input int e, input int code);
    int n;
    n = (code > MaxLen) ? MaxLen : code;
    for (int p = 0; p < n; p++) write_char(e, p, pick_char());
    write_len(e, code);
  endtask

  // Streams one search string. In exact mode it repeats the base entry for as
  // long as that entry is, otherwise it follows the entry loosely. Now and then
  // a table character is written just before one of the search characters.
  task automatic run_search(input int base, input int s_len, input bit exact);
    logic [CharW-1:0] ch;
    bit               copy;
    for (int k = 0; k < s_len; k++) begin
      copy = exact ? (k < shadow_len[base]) : ($urandom_range(0, 9) < 7);
      if (k < MaxLen && copy) ch = shadow_chr[base][k];
      else ch = pick_char();
      if ($urandom_range(0, 15) == 0)
        write_char($urandom_range(0, Entries - 1), $urandom_range(0, MaxLen - 1), pick_char());
      send_beat(OP_SEARCH, IndexW'($urandom_range(0, 15)), PosW'($urandom_range(0, 15)), ch,
                LengthW'($urandom_range(0, 31)), k == s_len - 1);
    end
  endtask

  // Stops offering beats and waits until every expected result has come out,
  // plus the block's latency for any table write still in flight.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_entry_count(input int value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= LengthW'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_count++;
  endtask

  initial begin : stimulus
    int start_beats;
    int phase;
    int long_e;
    int e;
    int p;
    int pick;
    int code;
    int s_len;
    int n_search;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every length is read by each search character, so all of them are
    // written, as empty entries, before the first search.
    set_entry_count(Entries);
    for (int idx = 0; idx < Entries; idx++) write_len(idx, 0);

    // Directed part. With only empty entries, entry zero matches anything.
    send_beat(OP_SEARCH, '0, '0, "z", '0, 1'b1);
    // Extreme characters in entry zero; an exact match, then a mismatch on the
    // second character that falls through to the empty entry one.
    write_char(0, 0, 8'hFF);
    write_char(0, 1, 8'h00);
    write_len(0, 2);
    send_beat(OP_SEARCH, '0, '0, 8'hFF, '0, 1'b0);
    send_beat(OP_SEARCH, '0, '0, 8'h00, '0, 1'b1);
    send_beat(OP_SEARCH, '1, '1, 8'hFF, '1, 1'b0);
    send_beat(OP_SEARCH, '1, '1, 8'h01, '1, 1'b1);
    // The unused op code must leave the search state alone.
    send_beat(OpUnused, '1, '1, 8'hFF, '1, 1'b1);
    // Only entry zero in use, and it mismatches: not found.
    set_entry_count(1);
    send_beat(OP_SEARCH, '0, '0, 8'h01, '0, 1'b1);
    // No entry in use at all.
    set_entry_count(0);
    send_beat(OP_SEARCH, '0, '0, "a", '0, 1'b1);
    // A count above the table size acts as the full table. A character written
    // in the middle of a search applies to the characters after it.
    set_entry_count(31);
    send_beat(OP_SEARCH, '0, '0, 8'hFF, '0, 1'b0);
    write_char(0, 1, 8'h05);
    send_beat(OP_SEARCH, '0, '0, 8'h05, '0, 1'b1);

    // Random part: each phase may change entry_count, rewrites a few entries
    // and then runs a handful of searches against the table.
    start_beats = beat_count;
    phase       = 0;
    while ((beat_count - start_beats) < RandomItems || result_count < MinResults) begin
      fast_phase = ($urandom_range(0, 3) == 0);
      if (phase == 0) begin
        // Fill the whole table with short strings and one entry whose length
        // code is above the maximum, so it is stored with the maximum length.
        long_e = $urandom_range(0, Entries - 1);
        for (int idx = 0; idx < Entries; idx++)
          load_entry(idx, (idx == long_e) ? $urandom_range(MaxLen + 1, 31) : $urandom_range(1, 5));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          pick = $urandom_range(0, 99);
          if (pick < 30) set_entry_count(Entries);
          else if (pick < 40) set_entry_count(0);
          else if (pick < 50) set_entry_count(31);
          else set_entry_count($urandom_range(0, 31));
        end else if (phase % 5 == 0) begin
          // Let the block drain completely before the next burst.
          wait_idle();
        end
        repeat ($urandom_range(1, 3)) begin
          e = $urandom_range(0, Entries - 1);
          if ($urandom_range(0, 4) == 0) begin
            // Shorten or lengthen within the characters already present.
            p = 0;
            while (p < MaxLen && chr_written[e][p]) p++;
            write_len(e, $urandom_range(0, p));
          end else begin
            pick = $urandom_range(0, 99);
            if (pick < 5) code = 0;
            else if (pick < 80) code = $urandom_range(1, 6);
            else if (pick < 92) code = $urandom_range(7, MaxLen);
            else code = $urandom_range(MaxLen + 1, 31);
            load_entry(e, code);
          end
        end
        if ($urandom_range(0, 3) == 0)
          write_char($urandom_range(0, Entries - 1), $urandom_range(0, MaxLen - 1), pick_char());
        if ($urandom_range(0, 5) == 0)
          send_beat(OpUnused, IndexW'($urandom_range(0, 15)), PosW'($urandom_range(0, 15)),
                    CharW'($urandom_range(0, 255)), LengthW'($urandom_range(0, 31)),
                    1'($urandom_range(0, 1)));
      end

      n_search = $urandom_range(2, 6);
      for (int k = 0; k < n_search; k++) begin
        if (phase == 0 && k == 0) begin
          // A search longer than the maximum that follows the long entry.
          run_search(long_e, $urandom_range(MaxLen + 1, 20), 1'b1);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 80) s_len = $urandom_range(1, 6);
          else if (pick < 92) s_len = $urandom_range(7, 14);
          else s_len = $urandom_range(15, 20);
          run_search($urandom_range(0, Entries - 1), s_len, 1'($urandom_range(0, 1)));
        end
      end
      phase++;
    end

    fast_phase = 1'b0;
    wait_idle();
    repeat (4 * DrainCycles) @(posedge clk_i);

    $display("Covered %0d table and search beats in %0d phases with %0d entry_count writes.",
             beat_count, phase, cfg_count);
    $display("Checked %0d search results, %0d of them with a matching entry.",
             result_count, hit_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("string_table_prefix_match_tb OK");
    end else begin
      $display("string_table_prefix_match_tb NOT OK");
    end
    $finish;
  end

endmodule
